/* rtl/fca_pkg.sv */
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, constants and helpers for the chain allocator: table sizes,
// operation and status codes, and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fca_pkg;

  // Table geometry.
  localparam int NUM_BLOCKS       = 1024;
  localparam int FIRST_DATA_BLOCK = 2;
  localparam int BLK_W            = $clog2(NUM_BLOCKS);
  localparam int IDX_W            = BLK_W + 1;
  localparam int LINK_W           = 16;
  localparam int CNT_W            = 10;
  localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Stream word layout.
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int TDATA_W  = 24;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE_ONE   = 3'd1,
    OP_FREE_CHAIN = 3'd2,
    OP_TRUNCATE   = 3'd3,
    OP_SEEK       = 3'd4,
    OP_SEEK_EXT   = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BROKEN    = 2'd2,
    STAT_BAD_START = 2'd3
  } stat_t;

  // Table read address select.
  typedef enum logic {
    RD_START = 1'b0,
    RD_V     = 1'b1
  } rd_sel_t;

  // Table write address/data select.
  typedef enum logic [2:0] {
    WR_CLEAR      = 3'd0,
    WR_START_ZERO = 3'd1,
    WR_START_END  = 3'd2,
    WR_V_ZERO     = 3'd3,
    WR_NEW_END    = 3'd4,
    WR_LINK       = 3'd5
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;   // capture a new request word
    logic    rd_en;      // read the table
    rd_sel_t rd_sel;
    logic    wr_en;      // write the table
    wr_sel_t wr_sel;
    logic    v_ld;       // take the read link as the link in hand
    logic    adv;        // follow one hop
    logic    ext;        // step onto the block just linked at the tail
    logic    cnt_inc;    // one more block freed, allocated or linked
    logic    stat_ld;
    stat_t   stat_val;
    logic    clr_run;    // clearing pass steps one entry
    logic    scan_start; // free scan starts at the hint
    logic    scan_run;   // free scan issues one read
    logic    fnd_ld;     // latch the free block the scan found
    logic    out_ld;     // load the result word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic start_data;  // start block is a data block
    logic rd_zero;     // read link is free
    logic v_end;       // link in hand is the end mark
    logic v_data;      // link in hand names a data block
    logic v_eq_start;  // link in hand points back at the start block
    logic hops_zero;
    logic scan_found;
    logic scan_none;
    logic clr_done;
    logic out_free;    // result register can take a word
  } sts_t;

  // True when a link value names a data block.
  function automatic logic is_data(input logic [LINK_W-1:0] v);
    return (v >= LINK_W'(FIRST_DATA_BLOCK)) && (v < LINK_W'(NUM_BLOCKS));
  endfunction

endpackage

/* rtl/fca_dpath.sv */
// ----------------------------------------------------------------------------
// fca_dpath
// Datapath of the chain allocator: the link table memory, the request and
// walk registers, the free-block scan with its low-water hint, and the
// result register.
// ----------------------------------------------------------------------------
module fca_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fca_pkg::op_t              in_op,
  input  logic [fca_pkg::BLK_W-1:0] in_start,
  input  logic [fca_pkg::BLK_W-1:0] in_hops,
  input  fca_pkg::cmd_t             cmd,
  output fca_pkg::sts_t             sts,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [fca_pkg::BLK_W-1:0] out_result,
  output fca_pkg::stat_t            out_status,
  output logic [fca_pkg::CNT_W-1:0] out_count
);
  import fca_pkg::*;

  logic [LINK_W-1:0] mem [NUM_BLOCKS];
  logic [LINK_W-1:0] rdata_r;

  op_t              op_r;
  logic [BLK_W-1:0] start_r;
  logic [BLK_W-1:0] hops_r;
  logic [BLK_W-1:0] cur_r;
  logic [LINK_W-1:0] v_r;
  logic [CNT_W-1:0] cnt_r;
  stat_t            stat_r;
  logic [BLK_W-1:0] fnd_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] hint_r;
  logic             pend_v_r;
  logic [BLK_W-1:0] pend_a_r;
  logic             out_valid_r;
  logic [BLK_W-1:0] out_result_r;
  stat_t            out_status_r;
  logic [CNT_W-1:0] out_count_r;

  logic             idx_in_range;
  logic             rd_en;
  logic [BLK_W-1:0] rd_addr;
  logic [BLK_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic [BLK_W-1:0] res;

  assign idx_in_range = idx_r < IDX_W'(NUM_BLOCKS);

  // Read port: the scan owns it while it runs.
  always_comb begin
    rd_en   = cmd.rd_en;
    rd_addr = start_r;
    if (cmd.scan_run) begin
      rd_en   = idx_in_range;
      rd_addr = idx_r[BLK_W-1:0];
    end else begin
      case (cmd.rd_sel)
        RD_START: rd_addr = start_r;
        RD_V:     rd_addr = v_r[BLK_W-1:0];
        default:  rd_addr = start_r;
      endcase
    end
  end

  // Write port address and data.
  always_comb begin
    case (cmd.wr_sel)
      WR_CLEAR: begin
        wr_addr = idx_r[BLK_W-1:0];
        wr_data = (idx_r < IDX_W'(FIRST_DATA_BLOCK)) ? END_MARK : '0;
      end
      WR_START_ZERO: begin
        wr_addr = start_r;
        wr_data = '0;
      end
      WR_START_END: begin
        wr_addr = start_r;
        wr_data = END_MARK;
      end
      WR_V_ZERO: begin
        wr_addr = v_r[BLK_W-1:0];
        wr_data = '0;
      end
      WR_NEW_END: begin
        wr_addr = fnd_r;
        wr_data = END_MARK;
      end
      WR_LINK: begin
        wr_addr = cur_r;
        wr_data = LINK_W'(fnd_r);
      end
      default: begin
        wr_addr = start_r;
        wr_data = '0;
      end
    endcase
  end

  // Link table, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r    <= in_op;
      start_r <= in_start;
      hops_r  <= in_hops;
      cur_r   <= in_start;
      cnt_r   <= '0;
      stat_r  <= STAT_OK;
    end
    if (cmd.stat_ld) begin
      stat_r <= cmd.stat_val;
    end
    if (cmd.cnt_inc && (cnt_r != CNT_MAX)) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.v_ld) begin
      v_r <= rdata_r;
    end
    if (cmd.adv) begin
      cur_r  <= v_r[BLK_W-1:0];
      v_r    <= rdata_r;
      hops_r <= hops_r - 1'b1;
    end
    if (cmd.ext) begin
      cur_r  <= fnd_r;
      v_r    <= END_MARK;
      hops_r <= hops_r - 1'b1;
    end
    if (cmd.fnd_ld) begin
      fnd_r <= pend_a_r;
    end
    if (cmd.scan_run) begin
      pend_a_r <= idx_r[BLK_W-1:0];
    end
  end

  // Clearing pass and scan pointer; the hint keeps every data block below it
  // in use, so a scan never has to look lower.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      hint_r   <= IDX_W'(FIRST_DATA_BLOCK);
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.clr_run) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.scan_start) begin
        idx_r    <= hint_r;
        pend_v_r <= 1'b0;
      end else if (cmd.scan_run) begin
        pend_v_r <= idx_in_range;
        if (idx_in_range) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.wr_en && (wr_data == '0) && ({1'b0, wr_addr} < hint_r)) begin
        hint_r <= {1'b0, wr_addr};
      end else if (cmd.wr_en && (cmd.wr_sel == WR_NEW_END)) begin
        hint_r <= {1'b0, fnd_r} + 1'b1;
      end
    end
  end

  // Result block depends on the request kind.
  always_comb begin
    res = '0;
    if (stat_r == STAT_OK) begin
      case (op_r)
        OP_ALLOC:    res = fnd_r;
        OP_SEEK:     res = cur_r;
        OP_SEEK_EXT: res = cur_r;
        default:     res = '0;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_result_r <= res;
      out_status_r <= stat_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // Status toward the controller.
  always_comb begin
    sts.op         = op_r;
    sts.start_data = is_data(LINK_W'(start_r));
    sts.rd_zero    = (rdata_r == '0);
    sts.v_end      = (v_r == END_MARK);
    sts.v_data     = is_data(v_r);
    sts.v_eq_start = (v_r == LINK_W'(start_r));
    sts.hops_zero  = (hops_r == '0);
    sts.scan_found = pend_v_r && (rdata_r == '0);
    sts.scan_none  = !pend_v_r && !idx_in_range;
    sts.clr_done   = (idx_r == IDX_W'(NUM_BLOCKS - 1));
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

/* rtl/fca_ctrl.sv */
// ----------------------------------------------------------------------------
// fca_ctrl
// Controller of the chain allocator: sequences the clearing pass after reset
// and each request through table reads, writes and the free-block scan.
// ----------------------------------------------------------------------------
module fca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fca_pkg::sts_t sts,
  output fca_pkg::cmd_t cmd
);
  import fca_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RD_START,
    S_CHAIN_CHK,
    S_CHAIN_RD,
    S_SEEK,
    S_SEEK_RD,
    S_SCAN,
    S_ALLOC_WR,
    S_LINK_WR,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_CLEAR;
        cmd.clr_run = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts.op)
          OP_ALLOC: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          OP_FREE_ONE, OP_FREE_CHAIN, OP_TRUNCATE, OP_SEEK, OP_SEEK_EXT: begin
            if (!sts.start_data) begin
              cmd.stat_ld  = 1'b1;
              cmd.stat_val = STAT_BAD_START;
              state_nxt    = S_FINISH;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_START;
              state_nxt  = S_RD_START;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end

      // Link of the start block is on the read port.
      S_RD_START: begin
        cmd.v_ld = 1'b1;
        if (sts.op == OP_FREE_ONE) begin
          if (!sts.rd_zero) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_START_ZERO;
            cmd.cnt_inc = 1'b1;
          end
          state_nxt = S_FINISH;
        end else if (sts.rd_zero) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_BROKEN;
          state_nxt    = S_FINISH;
        end else if (sts.op == OP_FREE_CHAIN) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_START_ZERO;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_CHAIN_CHK;
        end else if (sts.op == OP_TRUNCATE) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_START_END;
          state_nxt  = S_CHAIN_CHK;
        end else begin
          state_nxt = S_SEEK;
        end
      end

      // Free or truncate: check the link in hand before following it.
      S_CHAIN_CHK: begin
        if (sts.v_end) begin
          state_nxt = S_FINISH;
        end else if (!sts.v_data || ((sts.op == OP_TRUNCATE) && sts.v_eq_start)) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_BROKEN;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_V;
          state_nxt  = S_CHAIN_RD;
        end
      end

      // A free target breaks the chain; otherwise release it and go on.
      S_CHAIN_RD: begin
        if (sts.rd_zero) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_BROKEN;
          state_nxt    = S_FINISH;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_V_ZERO;
          cmd.cnt_inc = 1'b1;
          cmd.v_ld    = 1'b1;
          state_nxt   = S_CHAIN_CHK;
        end
      end

      // Walk: one hop per pass, extending at the tail when asked to.
      S_SEEK: begin
        if (sts.hops_zero) begin
          state_nxt = S_FINISH;
        end else if (sts.v_end) begin
          if (sts.op == OP_SEEK_EXT) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.stat_ld  = 1'b1;
            cmd.stat_val = STAT_BROKEN;
            state_nxt    = S_FINISH;
          end
        end else if (!sts.v_data) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_BROKEN;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_V;
          state_nxt  = S_SEEK_RD;
        end
      end

      S_SEEK_RD: begin
        if (sts.rd_zero) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_BROKEN;
          state_nxt    = S_FINISH;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_SEEK;
        end
      end

      // Lowest free block, one table read per cycle from the hint.
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_found) begin
          cmd.fnd_ld = 1'b1;
          state_nxt  = S_ALLOC_WR;
        end else if (sts.scan_none) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_NO_FREE;
          state_nxt    = S_FINISH;
        end
      end

      S_ALLOC_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_NEW_END;
        if (sts.op == OP_ALLOC) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_LINK_WR;
        end
      end

      // Hook the new block onto the tail and step onto it.
      S_LINK_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_LINK;
        cmd.ext     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_SEEK;
      end

      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/fat_chain_allocator.sv */
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table keeper: allocates, frees, truncates and walks block
// chains held as one 16-bit next-link per block.
// ----------------------------------------------------------------------------
//   Channel | Direction | Word contents
//   --------+-----------+--------------------------------------------------
//   in_     | in        | tuser: operation; tdata: start_block, hop_count
//   out_    | out       | tuser: status; tdata: result_block, blocks_changed
//
// After reset a clearing pass writes all 1024 table entries, one per cycle,
// and no word is accepted until it ends. A free-block scan reads one table
// entry per cycle starting at the lowest block that may be free. The table
// memory takes one read and one write per cycle. A finished word waits in
// the result register while the next request is taken; a stalled result
// holds the block before its next result.
// ----------------------------------------------------------------------------
module fat_chain_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [9:0] start_block, [19:10] hop_count, [23:20] zero
  input  logic [fca_pkg::TDATA_W-1:0] in_tdata,
  // [2:0] operation
  input  logic [fca_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [9:0] result_block, [19:10] blocks_changed, [23:20] zero
  output logic [fca_pkg::TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [fca_pkg::STAT_W-1:0]  out_tuser
);
  import fca_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [BLK_W-1:0] res_block;
  stat_t            res_status;
  logic [CNT_W-1:0] res_count;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fca_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (op_t'(in_tuser)),
    .in_start   (in_tdata[BLK_W-1:0]),
    .in_hops    (in_tdata[2*BLK_W-1:BLK_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_result (res_block),
    .out_status (res_status),
    .out_count  (res_count)
  );

  // Result word packing.
  assign out_tdata = {{(TDATA_W - BLK_W - CNT_W){1'b0}}, res_count, res_block};
  assign out_tuser = res_status;

endmodule

/* rtl/fca_checker.sv */
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks on the chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fca_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [fca_pkg::TDATA_W-1:0] out_tdata,
  input logic [fca_pkg::STAT_W-1:0]  out_tuser
);
  import fca_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Any failing status carries block 0.
  a_fail_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> out_tdata[BLK_W-1:0] == '0)
    else $error("failing result names a block");

  // A bad start block changes nothing.
  a_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_BAD_START) |-> out_tdata[BLK_W+CNT_W-1:BLK_W] == '0)
    else $error("bad start block reported changes");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("word accepted during clearing pass");

  // Padding above the result fields stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:BLK_W+CNT_W] == '0)
    else $error("result padding not zero");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);

/* sim/fat_chain_allocator_test.sv */
// ----------------------------------------------------------------------------
// fat_chain_allocator_test
// Self-checking bench for the chain allocator. A shadow copy of the link
// table predicts every result word as requests are queued. A clocked driver
// feeds the queued words with random gaps, and a clocked monitor checks each
// result word against the oldest prediction. Directed requests come first,
// then chunks of random requests built mostly from the blocks in use.
// ----------------------------------------------------------------------------
module fat_chain_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fca_pkg::*;

  localparam int unsigned RUN_LIMIT  = 30_000_000;
  localparam int          DRAIN_WAIT = 64;
  localparam int          HOLD_LEN   = 600;
  localparam int          CHUNK_LEN  = 111;
  localparam int          NUM_CHUNKS = 5;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] hops;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    stat_t            stat;
    logic [CNT_W-1:0] changed;
  } res_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic [OP_W-1:0]      in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic [STAT_W-1:0]    out_tuser;

  // Predicted link table, advanced as each request is queued.
  logic [LINK_W-1:0] fat [NUM_BLOCKS];

  req_t        req_backlog[$];
  res_t        due_results[$];
  int          err_cnt   = 0;
  int          idle_pct  = 26;
  bit          hold_go   = 1'b0;
  int unsigned cycle_cnt = 0;

  fat_chain_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Free-running clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A block number that can hold file data.
  function automatic bit in_data_area(input logic [LINK_W-1:0] v);
    return v >= LINK_W'(FIRST_DATA_BLOCK) && v < LINK_W'(NUM_BLOCKS);
  endfunction

  // A link is worth following when it names a data block that is in use.
  function automatic bit link_ok(input logic [LINK_W-1:0] v);
    return in_data_area(v) && fat[v[BLK_W-1:0]] != '0;
  endfunction

  // Claims the lowest free data block as a new chain end; 0 when full.
  function automatic logic [BLK_W-1:0] claim_lowest_free();
    for (int b = FIRST_DATA_BLOCK; b < NUM_BLOCKS; b++) begin
      if (fat[b] == '0) begin
        fat[b] = END_MARK;
        return BLK_W'(b);
      end
    end
    return '0;
  endfunction

  // Runs one request on the shadow table and returns the result word.
  function automatic res_t apply_to_shadow_fat(input req_t r);
    res_t             e;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] head;
    logic [BLK_W-1:0]  got;
    int               cnt;
    bit               done;
    e.blk     = '0;
    e.stat    = STAT_OK;
    e.changed = '0;
    cnt       = 0;
    done      = 1'b0;
    head      = LINK_W'(r.start);
    if (r.op == OP_ALLOC) begin
      got = claim_lowest_free();
      if (got == '0) begin
        e.stat = STAT_NO_FREE;
      end else begin
        e.blk = got;
        cnt   = 1;
      end
    end else if (r.op > OP_SEEK_EXT) begin
      // Unknown operations leave everything alone.
    end else if (!in_data_area(head)) begin
      e.stat = STAT_BAD_START;
    end else if (r.op == OP_FREE_ONE) begin
      if (fat[r.start] != '0) begin
        fat[r.start] = '0;
        cnt          = 1;
      end
    end else if (fat[r.start] == '0) begin
      e.stat = STAT_BROKEN;
    end else if (r.op == OP_FREE_CHAIN) begin
      cur = head;
      while (!done) begin
        nxt = fat[cur[BLK_W-1:0]];
        fat[cur[BLK_W-1:0]] = '0;
        cnt++;
        if (nxt == END_MARK) begin
          done = 1'b1;
        end else if (!link_ok(nxt)) begin
          e.stat = STAT_BROKEN;
          done   = 1'b1;
        end else begin
          cur = nxt;
        end
      end
    end else if (r.op == OP_TRUNCATE) begin
      cur = fat[r.start];
      fat[r.start] = END_MARK;
      while (cur != END_MARK && !done) begin
        // A link that loops back to the head counts as broken.
        if (cur == head || !link_ok(cur)) begin
          e.stat = STAT_BROKEN;
          done   = 1'b1;
        end else begin
          nxt = fat[cur[BLK_W-1:0]];
          fat[cur[BLK_W-1:0]] = '0;
          cnt++;
          cur = nxt;
        end
      end
    end else begin
      // Walk, and when extending, hang a fresh block on the tail.
      cur = head;
      for (int i = 0; i < int'(r.hops) && !done; i++) begin
        nxt = fat[cur[BLK_W-1:0]];
        if (nxt == END_MARK) begin
          if (r.op == OP_SEEK) begin
            e.stat = STAT_BROKEN;
            done   = 1'b1;
          end else begin
            got = claim_lowest_free();
            if (got == '0) begin
              e.stat = STAT_NO_FREE;
              done   = 1'b1;
            end else begin
              fat[cur[BLK_W-1:0]] = LINK_W'(got);
              cnt++;
              cur = LINK_W'(got);
            end
          end
        end else if (!link_ok(nxt)) begin
          e.stat = STAT_BROKEN;
          done   = 1'b1;
        end else begin
          cur = nxt;
        end
      end
      if (e.stat == STAT_OK) e.blk = cur[BLK_W-1:0];
    end
    e.changed = (cnt > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(cnt);
    return e;
  endfunction

  // Queues one request together with its predicted result.
  task automatic queue_request(input logic [OP_W-1:0] op, input int start, input int hops);
    req_t r;
    r.op    = op;
    r.start = BLK_W'(start);
    r.hops  = BLK_W'(hops);
    req_backlog.push_back(r);
    due_results.push_back(apply_to_shadow_fat(r));
  endtask

  // Some block in use, searched from a random point; random if none is.
  function automatic int pick_used_block();
    int span;
    int base;
    int b;
    span = NUM_BLOCKS - FIRST_DATA_BLOCK;
    base = $urandom_range(span - 1);
    for (int k = 0; k < span; k++) begin
      b = FIRST_DATA_BLOCK + (base + k) % span;
      if (fat[b] != '0) return b;
    end
    return base + FIRST_DATA_BLOCK;
  endfunction

  // Mostly well-formed requests on live chains, with some noise.
  task automatic queue_random_request();
    int               sel;
    int               start;
    int               hops;
    logic [OP_W-1:0]  op;
    sel = $urandom_range(99);
    if (sel < 22)      op = OP_ALLOC;
    else if (sel < 32) op = OP_FREE_ONE;
    else if (sel < 43) op = OP_FREE_CHAIN;
    else if (sel < 52) op = OP_TRUNCATE;
    else if (sel < 70) op = OP_SEEK;
    else if (sel < 96) op = OP_SEEK_EXT;
    else               op = OP_W'($urandom_range(7));
    if ($urandom_range(99) < 80) start = pick_used_block();
    else                         start = $urandom_range(NUM_BLOCKS - 1);
    sel = $urandom_range(99);
    if (sel < 55)      hops = $urandom_range(4);
    else if (sel < 90) hops = $urandom_range(24);
    else               hops = $urandom_range(NUM_BLOCKS - 1);
    queue_request(op, start, hops);
  endtask

  // Blocks until every queued word went in and every result came back.
  task automatic wait_all_done();
    while (req_backlog.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: takes the next word once the current one is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, req_backlog[0].hops, req_backlog[0].start};
        in_tuser  <= req_backlog[0].op;
        void'(req_backlog.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure, with one long hold so the block backs up.
  always @(posedge clk) begin : ready_gen
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Result monitor: every accepted word against the oldest prediction.
  always @(posedge clk) begin : result_check
    res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: tdata %h, tuser %h", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_res = due_results.pop_front();
        if (out_tdata[BLK_W-1:0] !== exp_res.blk) begin
          $error("result_block: expected %0d, got %0d", exp_res.blk, out_tdata[BLK_W-1:0]);
          err_cnt++;
        end
        if (out_tuser !== exp_res.stat) begin
          $error("status: expected %0d, got %0d", exp_res.stat, out_tuser);
          err_cnt++;
        end
        if (out_tdata[BLK_W+CNT_W-1:BLK_W] !== exp_res.changed) begin
          $error("blocks_changed: expected %0d, got %0d", exp_res.changed,
                 out_tdata[BLK_W+CNT_W-1:BLK_W]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("fat_chain_allocator: mismatch");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    for (int b = 0; b < NUM_BLOCKS; b++)
      fat[b] = (b < FIRST_DATA_BLOCK) ? END_MARK : '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Build a short chain, walk it, and hit the start and end corner cases.
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_SEEK_EXT, 2, 3);
    queue_request(OP_SEEK, 2, 3);
    queue_request(OP_SEEK, 2, 4);
    queue_request(OP_SEEK, 2, 0);
    queue_request(OP_SEEK, 0, 1);
    queue_request(OP_FREE_ONE, 1, 0);
    queue_request(OP_FREE_CHAIN, 0, 0);
    queue_request(OP_SEEK_EXT, 1023, 0);
    queue_request(OP_TRUNCATE, 2, 0);
    queue_request(OP_FREE_ONE, 2, 0);
    queue_request(OP_FREE_ONE, 2, 0);
    queue_request(OP_FREE_CHAIN, 700, 0);
    queue_request(3'd6, 1023, 1023);
    queue_request(3'd7, 5, 512);
    // Break a chain in the middle, then walk and free across the break.
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_SEEK_EXT, 2, 2);
    queue_request(OP_FREE_ONE, 3, 0);
    queue_request(OP_SEEK, 2, 2);
    queue_request(OP_FREE_CHAIN, 2, 0);
    // Fill the whole table from one chain, then empty it again.
    queue_request(OP_SEEK_EXT, 4, 1023);
    queue_request(OP_ALLOC, 0, 0);
    queue_request(OP_SEEK, 1023, 0);
    queue_request(OP_TRUNCATE, 4, 0);
    queue_request(OP_FREE_CHAIN, 4, 0);
    wait_all_done();

    // Random chunks; the sender pauses for a full drain after each one.
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      idle_pct = (c == 3) ? 0 : 26;
      for (int n = 0; n < CHUNK_LEN; n++) queue_random_request();
      if (c == 1) hold_go = 1'b1;
      wait_all_done();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_cnt == 0) begin
      $display("fat_chain_allocator: match");
    end else begin
      $display("fat_chain_allocator: mismatch");
    end
    $finish;
  end

endmodule
